[sv/bgr2yuv_pkg.sv]
// ----------------------------------------------------------------------------
// bgr2yuv_pkg
// Shared sizes, coefficients, types and helpers for the BGR to YUV 4:2:0 block.
// ----------------------------------------------------------------------------
`default_nettype none

package bgr2yuv_pkg;

    // Frame size limits
    localparam int MAX_WIDTH  = 4096;
    localparam int MAX_HEIGHT = 4096;
    localparam int MIN_DIM    = 2;

    // Field widths
    localparam int DIM_W   = 13;                       // frame size registers
    localparam int COL_W   = $clog2(MAX_WIDTH);        // column counter
    localparam int ROW_W   = $clog2(MAX_HEIGHT);       // row counter
    localparam int PIX_W   = 8;
    localparam int LIDX_W  = 24;
    localparam int CIDX_W  = 22;
    localparam int ACC_W   = 26;                       // Q16 accumulator, signed

    // Configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = DIM_W;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'd1;

    localparam logic [DIM_W-1:0] WIDTH_RESET  = 13'd1920;
    localparam logic [DIM_W-1:0] HEIGHT_RESET = 13'd1080;

    // BT.601 coefficients, Q16, rounded to nearest
    localparam logic signed [ACC_W-1:0] Y_R = 26'sd19595;
    localparam logic signed [ACC_W-1:0] Y_G = 26'sd38470;
    localparam logic signed [ACC_W-1:0] Y_B = 26'sd7471;
    localparam logic signed [ACC_W-1:0] U_R = -26'sd9634;
    localparam logic signed [ACC_W-1:0] U_G = -26'sd18940;
    localparam logic signed [ACC_W-1:0] U_B = 26'sd28574;
    localparam logic signed [ACC_W-1:0] V_R = 26'sd40305;
    localparam logic signed [ACC_W-1:0] V_G = -26'sd33751;
    localparam logic signed [ACC_W-1:0] V_B = -26'sd6554;
    localparam logic signed [ACC_W-1:0] C_OFS = 26'sd8388608;   // 128 in Q16

    // Pixel held between input register and result register
    typedef struct packed {
        logic [PIX_W-1:0] blue;
        logic [PIX_W-1:0] green;
        logic [PIX_W-1:0] red;
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] row;
        logic             last;
    } stage_t;

    // One result
    typedef struct packed {
        logic [PIX_W-1:0]  luma;
        logic [LIDX_W-1:0] luma_index;
        logic              chroma_valid;
        logic [PIX_W-1:0]  chroma_u;
        logic [PIX_W-1:0]  chroma_v;
        logic [CIDX_W-1:0] chroma_index;
        logic              frame_end;
    } result_t;

    // Drop 16 fraction bits, clamp to 0..255
    function automatic logic [PIX_W-1:0] q16_to_byte(input logic signed [ACC_W-1:0] acc);
        logic [PIX_W-1:0] res;
        priority if (acc[ACC_W-1])
            res = '0;
        else if (|acc[ACC_W-2:16+PIX_W])
            res = '1;
        else
            res = acc[16+PIX_W-1:16];
        return res;
    endfunction

    // Keep a frame dimension within MIN_DIM..max_dim
    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                   input logic [DIM_W-1:0] max_dim);
        logic [DIM_W-1:0] res;
        priority if (v < DIM_W'(MIN_DIM))
            res = DIM_W'(MIN_DIM);
        else if (v > max_dim)
            res = max_dim;
        else
            res = v;
        return res;
    endfunction

endpackage

`default_nettype wire

[sv/bgr2yuv_pixel_if.sv]
// ----------------------------------------------------------------------------
// bgr2yuv_pixel_if
// Valid/ready channel carrying one BGR pixel per request.
// ----------------------------------------------------------------------------
`default_nettype none

interface bgr2yuv_pixel_if
    import bgr2yuv_pkg::*;
;
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] pixel_blue;
    logic [PIX_W-1:0] pixel_green;
    logic [PIX_W-1:0] pixel_red;

    modport source (output valid, output pixel_blue, output pixel_green,
                    output pixel_red, input ready);
    modport sink   (input valid, input pixel_blue, input pixel_green,
                    input pixel_red, output ready);
endinterface

`default_nettype wire

[sv/bgr2yuv_yuv_if.sv]
// ----------------------------------------------------------------------------
// bgr2yuv_yuv_if
// Valid/ready channel carrying one Y (and optional U/V) result per request.
// ----------------------------------------------------------------------------
`default_nettype none

interface bgr2yuv_yuv_if
    import bgr2yuv_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [PIX_W-1:0]  luma;
    logic [LIDX_W-1:0] luma_index;
    logic              chroma_valid;
    logic [PIX_W-1:0]  chroma_u;
    logic [PIX_W-1:0]  chroma_v;
    logic [CIDX_W-1:0] chroma_index;
    logic              frame_end;

    modport source (output valid, output luma, output luma_index, output chroma_valid,
                    output chroma_u, output chroma_v, output chroma_index,
                    output frame_end, input ready);
    modport sink   (input valid, input luma, input luma_index, input chroma_valid,
                    input chroma_u, input chroma_v, input chroma_index,
                    input frame_end, output ready);
endinterface

`default_nettype wire

[sv/bgr_to_yuv420_planar.sv]
// ----------------------------------------------------------------------------
// bgr_to_yuv420_planar
// BGR pixel stream to planar YUV 4:2:0 (BT.601, Q16 fixed point).
// ----------------------------------------------------------------------------
// Takes one pixel per cycle in raster order and returns one result per pixel,
// sustaining one request per clock while results are taken. An accepted pixel
// reaches the yuv channel through two register stages (input register, result
// register). Each stage holds its data under back-pressure, so the input
// stalls only when both stages are full and the result is not being taken.
// Every result has luma and its Y-plane index; pixels on even rows and even
// columns also carry U/V and the chroma-plane index, otherwise those are 0.
// frame_end marks the last pixel of a frame. Frame size is set through the
// cfg port (index 0 width, 1 height), clamped to 2..4096; write it only while
// the block is idle. Row and column counters are not reset by a write; a
// counter at or past the new last column/row wraps after its pixel.
// ----------------------------------------------------------------------------
`default_nettype none

module bgr_to_yuv420_planar
    import bgr2yuv_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    bgr2yuv_pixel_if.sink              pixel,
    bgr2yuv_yuv_if.source              yuv
);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [DIM_W-1:0] width_reg;
    logic [DIM_W-1:0] height_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_FRAME_WIDTH:  width_reg  <= cfg_data;
                REG_FRAME_HEIGHT: height_reg <= cfg_data;
                default:          ;
            endcase
        end
    end

    // Effective frame size
    logic [DIM_W-1:0] w_eff;
    logic [DIM_W-1:0] h_eff;

    assign w_eff = clamp_dim(width_reg, DIM_W'(MAX_WIDTH));
    assign h_eff = clamp_dim(height_reg, DIM_W'(MAX_HEIGHT));

    // ------------------------------------------------------------------
    // Handshake / pipeline control
    // ------------------------------------------------------------------
    logic s1_valid_reg;
    logic out_valid_reg;
    logic out_load;     // result register takes stage 1
    logic s1_load;      // input register takes a new request
    logic in_accept;

    assign out_load    = s1_valid_reg && (!out_valid_reg || yuv.ready);
    assign pixel.ready = !s1_valid_reg || out_load;
    assign in_accept   = pixel.valid && pixel.ready;
    assign s1_load     = in_accept;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_load)
                s1_valid_reg <= 1'b1;
            else if (out_load)
                s1_valid_reg <= 1'b0;

            if (out_load)
                out_valid_reg <= 1'b1;
            else if (yuv.ready)
                out_valid_reg <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Raster position counters, advance on each accepted pixel
    // ------------------------------------------------------------------
    logic [COL_W-1:0] col_reg;
    logic [ROW_W-1:0] row_reg;
    logic [COL_W-1:0] col_next;
    logic [ROW_W-1:0] row_next;
    logic             last_col;
    logic             last_row;

    // counter at or beyond the last position counts as last
    assign last_col = (DIM_W'(col_reg) + DIM_W'(1)) >= w_eff;
    assign last_row = (DIM_W'(row_reg) + DIM_W'(1)) >= h_eff;

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (in_accept)
        begin
            if (last_col)
            begin
                col_next = '0;
                row_next = last_row ? '0 : row_reg + ROW_W'(1);
            end
            else
            begin
                col_next = col_reg + COL_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // ------------------------------------------------------------------
    // Input register
    // ------------------------------------------------------------------
    stage_t s1_reg;

    always_ff @(posedge clk)
    begin
        if (s1_load)
        begin
            s1_reg.blue  <= pixel.pixel_blue;
            s1_reg.green <= pixel.pixel_green;
            s1_reg.red   <= pixel.pixel_red;
            s1_reg.col   <= col_reg;
            s1_reg.row   <= row_reg;
            s1_reg.last  <= last_col && last_row;
        end
    end

    // ------------------------------------------------------------------
    // Color math and plane indices
    // ------------------------------------------------------------------
    logic signed [ACC_W-1:0] r_s;
    logic signed [ACC_W-1:0] g_s;
    logic signed [ACC_W-1:0] b_s;
    logic signed [ACC_W-1:0] y_acc;
    logic signed [ACC_W-1:0] u_acc;
    logic signed [ACC_W-1:0] v_acc;
    logic                    cvalid;
    logic [LIDX_W:0]         luma_full;     // one spare bit, dropped on truncation
    logic [CIDX_W:0]         chroma_full;
    result_t                 res_next;
    result_t                 out_reg;

    assign r_s = signed'(ACC_W'(s1_reg.red));
    assign g_s = signed'(ACC_W'(s1_reg.green));
    assign b_s = signed'(ACC_W'(s1_reg.blue));

    assign y_acc = r_s * Y_R + g_s * Y_G + b_s * Y_B;
    assign u_acc = r_s * U_R + g_s * U_G + b_s * U_B + C_OFS;
    assign v_acc = r_s * V_R + g_s * V_G + b_s * V_B + C_OFS;

    assign cvalid = !s1_reg.col[0] && !s1_reg.row[0];

    // row * width + col
    assign luma_full = ((LIDX_W+1)'(s1_reg.row) * (LIDX_W+1)'(w_eff))
                     + (LIDX_W+1)'(s1_reg.col);
    // (row/2) * (width/2) + col/2
    assign chroma_full = ((CIDX_W+1)'(s1_reg.row[ROW_W-1:1])
                         * (CIDX_W+1)'(w_eff[DIM_W-1:1]))
                       + (CIDX_W+1)'(s1_reg.col[COL_W-1:1]);

    always_comb
    begin
        res_next.luma         = q16_to_byte(y_acc);
        res_next.luma_index   = luma_full[LIDX_W-1:0];
        res_next.chroma_valid = cvalid;
        res_next.chroma_u     = cvalid ? q16_to_byte(u_acc) : '0;
        res_next.chroma_v     = cvalid ? q16_to_byte(v_acc) : '0;
        res_next.chroma_index = cvalid ? chroma_full[CIDX_W-1:0] : '0;
        res_next.frame_end    = s1_reg.last;
    end

    // ------------------------------------------------------------------
    // Result register
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (out_load)
            out_reg <= res_next;
    end

    assign yuv.valid        = out_valid_reg;
    assign yuv.luma         = out_reg.luma;
    assign yuv.luma_index   = out_reg.luma_index;
    assign yuv.chroma_valid = out_reg.chroma_valid;
    assign yuv.chroma_u     = out_reg.chroma_u;
    assign yuv.chroma_v     = out_reg.chroma_v;
    assign yuv.chroma_index = out_reg.chroma_index;
    assign yuv.frame_end    = out_reg.frame_end;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // input stalls only when both stages are full
    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        !pixel.ready |-> (s1_valid_reg && out_valid_reg))
        else $error("input stalled with a free stage");

    // no chroma data on odd positions
    a_chroma_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_reg.chroma_valid)
            |-> (out_reg.chroma_u == '0 && out_reg.chroma_v == '0
                 && out_reg.chroma_index == '0))
        else $error("chroma fields set on a non-chroma pixel");

    // frame end returns the counters to the origin
    a_frame_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && last_col && last_row) |=> (col_reg == '0 && row_reg == '0))
        else $error("counters did not wrap at frame end");

    // counters move only on an accepted pixel
    a_count_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !in_accept |=> ($stable(col_reg) && $stable(row_reg)))
        else $error("counter moved without a request");

    // column steps by one inside a row
    a_col_step: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && !last_col) |=> (col_reg == $past(col_reg) + COL_W'(1)))
        else $error("column counter skipped");

endmodule

`default_nettype wire
